>>> hdl/vmmio_pkg.sv
// Shared types and constants of the virtio-mmio transport register block.
package vmmio_pkg;

    // Bus beat into the block
    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] offset;
        logic [3:0]  access_size;
        logic [31:0] write_value;
    } vmmio_req_t;

    // Result beat out of the block
    typedef struct packed {
        logic [31:0] read_data;
        logic        notify_valid;
        logic [2:0]  notify_queue;
        logic [2:0]  error_code;
    } vmmio_rsp_t;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RAISE = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_BAD_SIZE    = 3'd1;
    localparam logic [2:0] ERR_WRITE_ONLY  = 3'd2;
    localparam logic [2:0] ERR_READ_ONLY   = 3'd3;
    localparam logic [2:0] ERR_BAD_OFFSET  = 3'd4;
    localparam logic [2:0] ERR_CONFIG_AREA = 3'd5;
    localparam logic [2:0] ERR_ACK_MISMATCH = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEVICE_TYPE   = 3'd0;
    localparam logic [2:0] CFG_DEVICE_FEAT   = 3'd1;
    localparam logic [2:0] CFG_QUEUE_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_QUEUE_COUNT   = 3'd3;
    localparam logic [2:0] CFG_VENDOR        = 3'd4;
    localparam logic [2:0] CFG_VERSION       = 3'd5;

    // Register map
    localparam logic [11:0] OFF_MAGIC          = 12'h000;
    localparam logic [11:0] OFF_VERSION        = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID      = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID      = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT       = 12'h010;
    localparam logic [11:0] OFF_DEV_FEAT_SEL   = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT       = 12'h020;
    localparam logic [11:0] OFF_DRV_FEAT_SEL   = 12'h024;
    localparam logic [11:0] OFF_QUEUE_SEL      = 12'h030;
    localparam logic [11:0] OFF_QUEUE_NUM_MAX  = 12'h034;
    localparam logic [11:0] OFF_QUEUE_NUM      = 12'h038;
    localparam logic [11:0] OFF_QUEUE_READY    = 12'h044;
    localparam logic [11:0] OFF_QUEUE_NOTIFY   = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS     = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK        = 12'h064;
    localparam logic [11:0] OFF_STATUS         = 12'h070;
    localparam logic [11:0] OFF_DESC_LO        = 12'h080;
    localparam logic [11:0] OFF_DESC_HI        = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO       = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI       = 12'h094;
    localparam logic [11:0] OFF_USED_LO        = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI        = 12'h0a4;
    localparam logic [11:0] OFF_CONFIG_GEN     = 12'h0fc;
    localparam logic [11:0] CONFIG_AREA_BASE   = 12'h100;

    // Misc constants
    localparam logic [3:0]  ACCESS_BYTES   = 4'd4;
    localparam logic [31:0] MAGIC_VALUE    = 32'h74726976;
    localparam int          EVENT_IDX_BIT  = 29;
    localparam logic [15:0] PENDING_MAX    = 16'hffff;

endpackage

>>> hdl/virtio_mmio_transport_registers.sv
// Register file of a virtio-mmio transport: bus reads, writes and interrupt raises.
//
// Usage
//   Request channel: drive request and pulse start. A beat is taken at a rising
//   edge with start high and busy low; busy stays low, so one beat may be taken
//   every cycle.
//   Result channel: done is high for exactly one cycle with the result beat on
//   result. Every request beat gives exactly one result beat, in order.
//   Path: input register, then decode/update into the result register.
//   Throughput: 1 beat per cycle; the decode and state update for a beat all
//   sit between the input register and the result register.
//   Configuration: cfg_valid/cfg_ready with cfg_index (register number) and
//   cfg_data; cfg_ready is always high. Write only while no beat is in flight.
//   Indexes past the last register are taken and ignored.
//   Reset: rst_n low clears all transport state and loads the configuration
//   reset values; no clearing pass is needed, the block is usable right after.
//   Stalls: the receiver cannot hold results off; done marks a one-cycle beat.
module virtio_mmio_transport_registers
    import vmmio_pkg::*;
#(
    parameter int QUEUES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  vmmio_req_t request,
    output logic       done,
    output vmmio_rsp_t result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data
);

    // queue index width and width of a queue count (holds QUEUES itself)
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int CW = $clog2(QUEUES + 1);

    // ---------------- configuration registers ----------------
    logic [7:0]  device_type_reg;
    logic [63:0] device_feat_reg;
    logic [15:0] queue_limit_reg;
    logic [3:0]  queue_count_reg;
    logic [31:0] vendor_reg;
    logic [1:0]  version_reg;

    // ---------------- transport state ----------------
    logic [31:0] status_reg,        status_next;
    logic        dev_feat_sel_reg,  dev_feat_sel_next;
    logic        drv_feat_sel_reg,  drv_feat_sel_next;
    logic [63:0] drv_feat_reg,      drv_feat_next;
    logic [QW-1:0] queue_sel_reg,   queue_sel_next;
    logic [15:0] queue_size_reg  [QUEUES];
    logic [15:0] queue_size_next [QUEUES];
    logic        queue_ready_reg  [QUEUES];
    logic        queue_ready_next [QUEUES];
    logic [63:0] desc_addr_reg  [QUEUES];
    logic [63:0] desc_addr_next [QUEUES];
    logic [63:0] avail_addr_reg  [QUEUES];
    logic [63:0] avail_addr_next [QUEUES];
    logic [63:0] used_addr_reg  [QUEUES];
    logic [63:0] used_addr_next [QUEUES];
    logic        event_idx_reg  [QUEUES];
    logic        event_idx_next [QUEUES];
    logic [31:0] irq_bits_reg,      irq_bits_next;
    logic [15:0] irq_pending_reg,   irq_pending_next;

    // ---------------- pipeline registers ----------------
    vmmio_req_t  req_reg;
    logic        req_valid_reg;
    vmmio_rsp_t  rsp_reg,           rsp_next;
    logic        done_reg;

    logic [CW-1:0] usable_queues;
    logic [31:0]   wdata;

    // write one 32-bit half of a 64-bit register
    function automatic logic [63:0] set_half(input logic [63:0] old,
                                             input logic [31:0] v,
                                             input logic        high);
        logic [63:0] r;
        r = high ? {v, old[31:0]} : {old[63:32], v};
        return r;
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = rsp_reg;
    assign wdata     = req_reg.write_value;

    // min(queue_count, QUEUES)
    always_comb
    begin
        if (32'(queue_count_reg) < 32'(QUEUES))
            usable_queues = CW'(queue_count_reg);
        else
            usable_queues = CW'(QUEUES);
    end

    // ---------------- configuration port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_type_reg <= '0;
            device_feat_reg <= '0;
            queue_limit_reg <= 16'd256;
            queue_count_reg <= 4'd1;
            vendor_reg      <= '0;
            version_reg     <= 2'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEVICE_TYPE: device_type_reg <= cfg_data[7:0];
                CFG_DEVICE_FEAT: device_feat_reg <= cfg_data;
                CFG_QUEUE_LIMIT: queue_limit_reg <= cfg_data[15:0];
                CFG_QUEUE_COUNT: queue_count_reg <= cfg_data[3:0];
                CFG_VENDOR:      vendor_reg      <= cfg_data[31:0];
                CFG_VERSION:     version_reg     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ---------------- decode and update ----------------
    always_comb
    begin
        logic [QW-1:0] q;
        q = queue_sel_reg;

        status_next       = status_reg;
        dev_feat_sel_next = dev_feat_sel_reg;
        drv_feat_sel_next = drv_feat_sel_reg;
        drv_feat_next     = drv_feat_reg;
        queue_sel_next    = queue_sel_reg;
        queue_size_next   = queue_size_reg;
        queue_ready_next  = queue_ready_reg;
        desc_addr_next    = desc_addr_reg;
        avail_addr_next   = avail_addr_reg;
        used_addr_next    = used_addr_reg;
        event_idx_next    = event_idx_reg;
        irq_bits_next     = irq_bits_reg;
        irq_pending_next  = irq_pending_reg;
        rsp_next          = '0;

        if (req_valid_reg)
        begin
            unique case (req_reg.operation)
                OP_RAISE:
                begin
                    irq_bits_next = 32'd1;
                    if (irq_pending_reg != PENDING_MAX)
                        irq_pending_next = irq_pending_reg + 16'd1;
                end
                OP_READ, OP_WRITE:
                begin
                    if (req_reg.offset >= CONFIG_AREA_BASE)
                        rsp_next.error_code = ERR_CONFIG_AREA;
                    else if (req_reg.access_size != ACCESS_BYTES)
                        rsp_next.error_code = ERR_BAD_SIZE;
                    else if (req_reg.operation == OP_READ)
                    begin
                        unique case (req_reg.offset) inside
                            OFF_MAGIC:     rsp_next.read_data = MAGIC_VALUE;
                            OFF_VERSION:   rsp_next.read_data = 32'(version_reg);
                            OFF_DEVICE_ID: rsp_next.read_data = 32'(device_type_reg);
                            OFF_VENDOR_ID: rsp_next.read_data = vendor_reg;
                            OFF_DEV_FEAT:
                                rsp_next.read_data = dev_feat_sel_reg ?
                                    device_feat_reg[63:32] : device_feat_reg[31:0];
                            OFF_QUEUE_NUM_MAX:
                                rsp_next.read_data = 32'(queue_limit_reg);
                            OFF_QUEUE_READY:
                                rsp_next.read_data = 32'(queue_ready_reg[q]);
                            OFF_IRQ_STATUS: rsp_next.read_data = irq_bits_reg;
                            OFF_STATUS:     rsp_next.read_data = status_reg;
                            OFF_CONFIG_GEN: rsp_next.read_data = '0;
                            OFF_DEV_FEAT_SEL, OFF_DRV_FEAT, OFF_DRV_FEAT_SEL,
                            OFF_QUEUE_SEL, OFF_QUEUE_NUM, OFF_QUEUE_NOTIFY,
                            OFF_IRQ_ACK, OFF_DESC_LO, OFF_DESC_HI, OFF_AVAIL_LO,
                            OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI:
                                rsp_next.error_code = ERR_WRITE_ONLY;
                            default:
                                rsp_next.error_code = ERR_BAD_OFFSET;
                        endcase
                    end
                    else
                    begin
                        unique case (req_reg.offset) inside
                            OFF_DEV_FEAT_SEL: dev_feat_sel_next = (wdata != '0);
                            OFF_DRV_FEAT:
                            begin
                                drv_feat_next = set_half(drv_feat_reg, wdata,
                                                         drv_feat_sel_reg);
                                if (drv_feat_next[EVENT_IDX_BIT])
                                begin
                                    for (int i = 0; i < QUEUES; i++)
                                    begin
                                        if (i < int'(usable_queues))
                                            event_idx_next[i] = 1'b1;
                                    end
                                end
                            end
                            OFF_DRV_FEAT_SEL: drv_feat_sel_next = (wdata != '0);
                            OFF_QUEUE_SEL:
                            begin
                                if (wdata < 32'(usable_queues))
                                    queue_sel_next = QW'(wdata);
                            end
                            OFF_QUEUE_NUM:   queue_size_next[q]  = wdata[15:0];
                            OFF_QUEUE_READY: queue_ready_next[q] = wdata[0];
                            OFF_QUEUE_NOTIFY:
                            begin
                                // out-of-range notify is dropped silently
                                if (wdata < 32'(usable_queues))
                                begin
                                    rsp_next.notify_valid = 1'b1;
                                    rsp_next.notify_queue = wdata[2:0];
                                end
                            end
                            OFF_IRQ_ACK:
                            begin
                                // exact match with a count outstanding: retire one
                                if (wdata == irq_bits_reg && irq_pending_reg != '0)
                                    irq_pending_next = irq_pending_reg - 16'd1;
                                else
                                begin
                                    if (wdata != irq_bits_reg)
                                        rsp_next.error_code = ERR_ACK_MISMATCH;
                                    irq_bits_next = irq_bits_reg & ~wdata;
                                end
                            end
                            OFF_STATUS:
                            begin
                                status_next = wdata;
                                // status zero is a device reset
                                if (wdata == '0)
                                begin
                                    irq_bits_next    = '0;
                                    irq_pending_next = '0;
                                    for (int i = 0; i < QUEUES; i++)
                                    begin
                                        queue_size_next[i]  = '0;
                                        queue_ready_next[i] = 1'b0;
                                        desc_addr_next[i]   = '0;
                                        avail_addr_next[i]  = '0;
                                        used_addr_next[i]   = '0;
                                        event_idx_next[i]   = 1'b0;
                                    end
                                end
                            end
                            OFF_DESC_LO:
                                desc_addr_next[q] = set_half(desc_addr_reg[q], wdata, 1'b0);
                            OFF_DESC_HI:
                                desc_addr_next[q] = set_half(desc_addr_reg[q], wdata, 1'b1);
                            OFF_AVAIL_LO:
                                avail_addr_next[q] = set_half(avail_addr_reg[q], wdata, 1'b0);
                            OFF_AVAIL_HI:
                                avail_addr_next[q] = set_half(avail_addr_reg[q], wdata, 1'b1);
                            OFF_USED_LO:
                                used_addr_next[q] = set_half(used_addr_reg[q], wdata, 1'b0);
                            OFF_USED_HI:
                                used_addr_next[q] = set_half(used_addr_reg[q], wdata, 1'b1);
                            OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID,
                            OFF_DEV_FEAT, OFF_QUEUE_NUM_MAX, OFF_IRQ_STATUS,
                            OFF_CONFIG_GEN:
                                rsp_next.error_code = ERR_READ_ONLY;
                            default:
                                rsp_next.error_code = ERR_BAD_OFFSET;
                        endcase
                    end
                end
                default: ;  // unused operation code: no effect, zero result
            endcase
        end
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            done_reg         <= 1'b0;
            status_reg       <= '0;
            dev_feat_sel_reg <= 1'b0;
            drv_feat_sel_reg <= 1'b0;
            drv_feat_reg     <= '0;
            queue_sel_reg    <= '0;
            queue_size_reg   <= '{default: '0};
            queue_ready_reg  <= '{default: 1'b0};
            desc_addr_reg    <= '{default: '0};
            avail_addr_reg   <= '{default: '0};
            used_addr_reg    <= '{default: '0};
            event_idx_reg    <= '{default: 1'b0};
            irq_bits_reg     <= '0;
            irq_pending_reg  <= '0;
        end
        else
        begin
            req_valid_reg    <= start && !busy;
            done_reg         <= req_valid_reg;
            status_reg       <= status_next;
            dev_feat_sel_reg <= dev_feat_sel_next;
            drv_feat_sel_reg <= drv_feat_sel_next;
            drv_feat_reg     <= drv_feat_next;
            queue_sel_reg    <= queue_sel_next;
            queue_size_reg   <= queue_size_next;
            queue_ready_reg  <= queue_ready_next;
            desc_addr_reg    <= desc_addr_next;
            avail_addr_reg   <= avail_addr_next;
            used_addr_reg    <= used_addr_next;
            event_idx_reg    <= event_idx_next;
            irq_bits_reg     <= irq_bits_next;
            irq_pending_reg  <= irq_pending_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= request;
        rsp_reg <= rsp_next;
    end

    // ---------------- assertions ----------------
    // every taken beat gives exactly one result
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_valid_reg))
        else $error("result without a request beat");

    // a notify pulse is an ok write with no read data
    a_notify_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.notify_valid) |->
            (result.error_code == ERR_OK && result.read_data == '0))
        else $error("notify pulse with error or read data");

    // queue select never leaves the implemented queues
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(queue_sel_reg) < 32'(QUEUES))
        else $error("queue select out of range");

endmodule

>>> tb/virtio_mmio_transport_registers_tb.sv
// Self-checking testbench of the virtio-mmio transport register block.
`timescale 1ns / 100ps

module virtio_mmio_transport_registers_tb
    import vmmio_pkg::*;
();

    // Operation code 3 has no name in the package; the block ignores it.
    localparam logic [1:0] OP_NONE = 2'd3;
    // Config index past the last register: taken and dropped.
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int NQ = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PENDING_RUN = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    vmmio_req_t  request = '0;
    logic        done;
    vmmio_rsp_t  result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    virtio_mmio_transport_registers dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the transport: configuration and register state.
    // Register state is updated once per accepted request beat.
    // ------------------------------------------------------------------
    logic [7:0]  cfg_dev_type;
    logic [63:0] cfg_dev_features;
    logic [15:0] cfg_queue_limit;
    logic [3:0]  cfg_queue_count;
    logic [31:0] cfg_vendor;
    logic [1:0]  cfg_version;

    logic [31:0] dev_status;
    logic        dev_feat_sel;
    logic        drv_feat_sel;
    logic [63:0] drv_features;
    logic [2:0]  sel_queue;
    logic [15:0] q_size  [NQ];
    logic        q_ready [NQ];
    logic [63:0] q_desc  [NQ];
    logic [63:0] q_avail [NQ];
    logic [63:0] q_used  [NQ];
    logic        q_evidx [NQ];
    logic [31:0] irq_bits;
    logic [15:0] irq_pending;

    // Replies owed by the block, oldest first.
    vmmio_rsp_t  replies_due[$];

    int  mismatches = 0;
    int  cycles = 0;
    int  beats_sent = 0;
    bit  sender_gaps = 1'b1;

    function automatic int usable_queues();
        return (cfg_queue_count < NQ) ? int'(cfg_queue_count) : NQ;
    endfunction

    function automatic void wipe_queues();
        for (int i = 0; i < NQ; i++)
        begin
            q_size[i]  = '0;
            q_ready[i] = 1'b0;
            q_desc[i]  = '0;
            q_avail[i] = '0;
            q_used[i]  = '0;
            q_evidx[i] = 1'b0;
        end
    endfunction

    function automatic void reset_model();
        cfg_dev_type     = '0;
        cfg_dev_features = '0;
        cfg_queue_limit  = 16'd256;
        cfg_queue_count  = 4'd1;
        cfg_vendor       = '0;
        cfg_version      = 2'd2;
        dev_status       = '0;
        dev_feat_sel     = 1'b0;
        drv_feat_sel     = 1'b0;
        drv_features     = '0;
        sel_queue        = '0;
        irq_bits         = '0;
        irq_pending      = '0;
        wipe_queues();
    endfunction

    // One bus access against the shadow state; returns the reply it owes.
    function automatic vmmio_rsp_t mmio_access(input vmmio_req_t req);
        vmmio_rsp_t  rsp;
        logic [31:0] v;
        logic [2:0]  q;
        int          n;
        rsp = '0;
        v = req.write_value;
        q = sel_queue;
        n = usable_queues();

        // Device side raise: no decode, no size check.
        if (req.operation == OP_RAISE)
        begin
            irq_bits = 32'd1;
            if (irq_pending != PENDING_MAX)
                irq_pending = irq_pending + 16'd1;
            return rsp;
        end
        if (req.operation == OP_NONE)
            return rsp;
        // Config space wins over the size check.
        if (req.offset >= CONFIG_AREA_BASE)
        begin
            rsp.error_code = ERR_CONFIG_AREA;
            return rsp;
        end
        if (req.access_size != ACCESS_BYTES)
        begin
            rsp.error_code = ERR_BAD_SIZE;
            return rsp;
        end

        if (req.operation == OP_READ)
        begin
            case (req.offset)
                OFF_MAGIC:         rsp.read_data = MAGIC_VALUE;
                OFF_VERSION:       rsp.read_data = {30'd0, cfg_version};
                OFF_DEVICE_ID:     rsp.read_data = {24'd0, cfg_dev_type};
                OFF_VENDOR_ID:     rsp.read_data = cfg_vendor;
                OFF_DEV_FEAT:      rsp.read_data = dev_feat_sel ? cfg_dev_features[63:32]
                                                                : cfg_dev_features[31:0];
                OFF_QUEUE_NUM_MAX: rsp.read_data = {16'd0, cfg_queue_limit};
                OFF_QUEUE_READY:   rsp.read_data = {31'd0, q_ready[q]};
                OFF_IRQ_STATUS:    rsp.read_data = irq_bits;
                OFF_STATUS:        rsp.read_data = dev_status;
                OFF_CONFIG_GEN:    rsp.read_data = '0;
                OFF_DEV_FEAT_SEL, OFF_DRV_FEAT, OFF_DRV_FEAT_SEL, OFF_QUEUE_SEL,
                OFF_QUEUE_NUM, OFF_QUEUE_NOTIFY, OFF_IRQ_ACK, OFF_DESC_LO,
                OFF_DESC_HI, OFF_AVAIL_LO, OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI:
                    rsp.error_code = ERR_WRITE_ONLY;
                default:           rsp.error_code = ERR_BAD_OFFSET;
            endcase
            return rsp;
        end

        case (req.offset)
            OFF_DEV_FEAT_SEL: dev_feat_sel = (v != 0);
            OFF_DRV_FEAT:
            begin
                if (drv_feat_sel)
                    drv_features[63:32] = v;
                else
                    drv_features[31:0] = v;
                // Event index is sticky until a status reset.
                if (drv_features[EVENT_IDX_BIT])
                    for (int i = 0; i < n; i++)
                        q_evidx[i] = 1'b1;
            end
            OFF_DRV_FEAT_SEL: drv_feat_sel = (v != 0);
            OFF_QUEUE_SEL:
                if (v < 32'(n))
                    sel_queue = v[2:0];
            OFF_QUEUE_NUM:    q_size[q] = v[15:0];
            OFF_QUEUE_READY:  q_ready[q] = v[0];
            OFF_QUEUE_NOTIFY:
                if (v < 32'(n))
                begin
                    rsp.notify_valid = 1'b1;
                    rsp.notify_queue = v[2:0];
                end
            OFF_IRQ_ACK:
            begin
                // A matching ack with a count pending only drops the count.
                if (v == irq_bits && irq_pending != 0)
                    irq_pending = irq_pending - 16'd1;
                else
                begin
                    if (v != irq_bits)
                        rsp.error_code = ERR_ACK_MISMATCH;
                    irq_bits = irq_bits & ~v;
                end
            end
            OFF_STATUS:
            begin
                dev_status = v;
                if (v == 0)
                begin
                    irq_bits = '0;
                    irq_pending = '0;
                    wipe_queues();
                end
            end
            OFF_DESC_LO:  q_desc[q][31:0]   = v;
            OFF_DESC_HI:  q_desc[q][63:32]  = v;
            OFF_AVAIL_LO: q_avail[q][31:0]  = v;
            OFF_AVAIL_HI: q_avail[q][63:32] = v;
            OFF_USED_LO:  q_used[q][31:0]   = v;
            OFF_USED_HI:  q_used[q][63:32]  = v;
            OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID, OFF_DEV_FEAT,
            OFF_QUEUE_NUM_MAX, OFF_IRQ_STATUS, OFF_CONFIG_GEN:
                rsp.error_code = ERR_READ_ONLY;
            default:      rsp.error_code = ERR_BAD_OFFSET;
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Request side. A beat goes at an edge with start high and busy low.
    // start stays high between back-to-back beats; it only drops for a
    // gap or when the bus is settled.
    // ------------------------------------------------------------------
    task automatic send_access(input vmmio_req_t req);
        request <= req;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        replies_due.push_back(mmio_access(req));
        beats_sent++;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Stop sending and wait out every owed reply plus the pipe latency.
    task automatic settle_bus();
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic vmmio_req_t beat(input logic [1:0] op, input logic [11:0] off,
                                        input logic [31:0] val);
        vmmio_req_t r;
        r.operation   = op;
        r.offset      = off;
        r.access_size = ACCESS_BYTES;
        r.write_value = val;
        return r;
    endfunction

    // Config write; only called with the bus settled.
    task automatic write_config(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEVICE_TYPE: cfg_dev_type     = val[7:0];
            CFG_DEVICE_FEAT: cfg_dev_features = val;
            CFG_QUEUE_LIMIT: cfg_queue_limit  = val[15:0];
            CFG_QUEUE_COUNT: cfg_queue_count  = val[3:0];
            CFG_VENDOR:      cfg_vendor       = val[31:0];
            CFG_VERSION:     cfg_version      = val[1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] dtype, input logic [63:0] feat,
                                  input logic [15:0] limit, input logic [3:0] count,
                                  input logic [31:0] vendor, input logic [1:0] ver);
        settle_bus();
        write_config(CFG_DEVICE_TYPE, {56'd0, dtype});
        write_config(CFG_DEVICE_FEAT, feat);
        write_config(CFG_QUEUE_LIMIT, {48'd0, limit});
        write_config(CFG_QUEUE_COUNT, {60'd0, count});
        write_config(CFG_VENDOR, {32'd0, vendor});
        write_config(CFG_VERSION, {62'd0, ver});
    endtask

    function automatic logic [11:0] map_offset(input int k);
        case (k)
            0:  return OFF_MAGIC;
            1:  return OFF_VERSION;
            2:  return OFF_DEVICE_ID;
            3:  return OFF_VENDOR_ID;
            4:  return OFF_DEV_FEAT;
            5:  return OFF_DEV_FEAT_SEL;
            6:  return OFF_DRV_FEAT;
            7:  return OFF_DRV_FEAT_SEL;
            8:  return OFF_QUEUE_SEL;
            9:  return OFF_QUEUE_NUM_MAX;
            10: return OFF_QUEUE_NUM;
            11: return OFF_QUEUE_READY;
            12: return OFF_QUEUE_NOTIFY;
            13: return OFF_IRQ_STATUS;
            14: return OFF_IRQ_ACK;
            15: return OFF_STATUS;
            16: return OFF_DESC_LO;
            17: return OFF_DESC_HI;
            18: return OFF_AVAIL_LO;
            19: return OFF_AVAIL_HI;
            20: return OFF_USED_LO;
            21: return OFF_USED_HI;
            default: return OFF_CONFIG_GEN;
        endcase
    endfunction

    // Random beat, weighted toward mapped registers and values that hit
    // the interesting branches (in-range queue numbers, matching acks,
    // status resets).
    function automatic vmmio_req_t random_access();
        vmmio_req_t r;
        int         pick;
        pick = $urandom_range(0, 99);
        r.operation = (pick < 44) ? OP_READ : (pick < 88) ? OP_WRITE :
                      (pick < 97) ? OP_RAISE : OP_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 82)
            r.offset = map_offset($urandom_range(0, 22));
        else if (pick < 90)
            r.offset = 12'($urandom_range(0, 255));
        else
            r.offset = 12'($urandom_range(0, 4095));
        r.access_size = ($urandom_range(0, 9) != 0) ? ACCESS_BYTES
                                                   : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        case (r.offset)
            OFF_QUEUE_SEL, OFF_QUEUE_NOTIFY:
                r.write_value = (pick < 80) ? 32'($urandom_range(0, 9)) : $urandom;
            OFF_IRQ_ACK:
                r.write_value = (pick < 50) ? irq_bits :
                                (pick < 70) ? 32'($urandom_range(0, 3)) : $urandom;
            OFF_STATUS:
                r.write_value = (pick < 25) ? 32'd0 :
                                (pick < 60) ? 32'($urandom_range(0, 255)) : $urandom;
            OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL:
                r.write_value = (pick < 40) ? 32'd0 : (pick < 80) ? 32'd1 : $urandom;
            default:
                r.write_value = $urandom;
        endcase
        return r;
    endfunction

    // Driver bring-up of one queue, random content, as a guest would do it.
    task automatic driver_bringup();
        logic [31:0] qn;
        qn = 32'($urandom_range(0, usable_queues() - 1));
        send_access(beat(OP_WRITE, OFF_STATUS, 32'd0));
        send_access(beat(OP_WRITE, OFF_STATUS, 32'd1));
        send_access(beat(OP_WRITE, OFF_STATUS, 32'd3));
        send_access(beat(OP_WRITE, OFF_DEV_FEAT_SEL, 32'($urandom_range(0, 1))));
        send_access(beat(OP_READ, OFF_DEV_FEAT, $urandom));
        send_access(beat(OP_WRITE, OFF_DRV_FEAT_SEL, 32'd0));
        send_access(beat(OP_WRITE, OFF_DRV_FEAT, $urandom));
        send_access(beat(OP_WRITE, OFF_DRV_FEAT_SEL, 32'd1));
        send_access(beat(OP_WRITE, OFF_DRV_FEAT, $urandom));
        send_access(beat(OP_WRITE, OFF_STATUS, 32'd11));
        send_access(beat(OP_WRITE, OFF_QUEUE_SEL, qn));
        send_access(beat(OP_READ, OFF_QUEUE_NUM_MAX, $urandom));
        send_access(beat(OP_WRITE, OFF_QUEUE_NUM, $urandom));
        send_access(beat(OP_WRITE, OFF_DESC_LO, $urandom));
        send_access(beat(OP_WRITE, OFF_DESC_HI, $urandom));
        send_access(beat(OP_WRITE, OFF_AVAIL_LO, $urandom));
        send_access(beat(OP_WRITE, OFF_AVAIL_HI, $urandom));
        send_access(beat(OP_WRITE, OFF_USED_LO, $urandom));
        send_access(beat(OP_WRITE, OFF_USED_HI, $urandom));
        send_access(beat(OP_WRITE, OFF_QUEUE_READY, 32'd1));
        send_access(beat(OP_READ, OFF_QUEUE_READY, $urandom));
        send_access(beat(OP_WRITE, OFF_STATUS, 32'd15));
        send_access(beat(OP_WRITE, OFF_QUEUE_NOTIFY, qn));
        send_access(beat(OP_RAISE, 12'($urandom), $urandom));
        send_access(beat(OP_READ, OFF_IRQ_STATUS, $urandom));
        send_access(beat(OP_WRITE, OFF_IRQ_ACK, irq_bits));
    endtask

    // ------------------------------------------------------------------
    // Reply side: done marks a one-cycle beat that cannot be held off.
    // Values are sampled as they stood before the edge.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : reply_check
        vmmio_rsp_t want;
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual %h",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("read_data", want.read_data, result.read_data);
                check_field("notify_valid", 32'(want.notify_valid), 32'(result.notify_valid));
                check_field("notify_queue", 32'(want.notify_queue), 32'(result.notify_queue));
                check_field("error_code", 32'(want.error_code), 32'(result.error_code));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("virtio_mmio_transport_registers_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identity registers straight after reset.
    task automatic test_identity_reads();
        send_access(beat(OP_READ, OFF_MAGIC, '0));
        send_access(beat(OP_READ, OFF_DEV_FEAT, '0));
        send_access(beat(OP_READ, OFF_CONFIG_GEN, 32'hffffffff));
    endtask

    // Size, offset and direction refusals, and the ignored operation.
    task automatic test_refused_accesses();
        vmmio_req_t r;
        r = beat(OP_READ, OFF_MAGIC, '0);
        r.access_size = 4'd0;
        send_access(r);
        r = beat(OP_WRITE, OFF_STATUS, 32'hffffffff);
        r.access_size = 4'd15;
        send_access(r);
        send_access(beat(OP_READ, 12'hfff, '0));
        // config space is reported even when the size is also wrong
        r = beat(OP_READ, CONFIG_AREA_BASE, '0);
        r.access_size = 4'd8;
        send_access(r);
        send_access(beat(OP_READ, 12'h018, '0));
        send_access(beat(OP_WRITE, OFF_MAGIC, 32'h1));
        send_access(beat(OP_READ, OFF_QUEUE_NOTIFY, '0));
        r = '1;
        r.operation = OP_NONE;
        send_access(r);
    endtask

    // Queue select range, notify range, feature halves and selects.
    task automatic test_queues_and_features();
        apply_settings(8'h5a, 64'hdead_beef_0123_4567, 16'd1024, 4'd8, 32'h1af4, 2'd1);
        write_config(CFG_UNUSED, '1);
        send_access(beat(OP_WRITE, OFF_QUEUE_SEL, 32'd5));
        send_access(beat(OP_WRITE, OFF_QUEUE_READY, 32'hffffffff));
        send_access(beat(OP_WRITE, OFF_QUEUE_SEL, 32'd8));
        send_access(beat(OP_READ, OFF_QUEUE_READY, '0));
        send_access(beat(OP_WRITE, OFF_QUEUE_NOTIFY, 32'd7));
        send_access(beat(OP_WRITE, OFF_QUEUE_NOTIFY, 32'd8));
        send_access(beat(OP_WRITE, OFF_DEV_FEAT_SEL, 32'h8000_0000));
        send_access(beat(OP_READ, OFF_DEV_FEAT, '0));
        send_access(beat(OP_WRITE, OFF_DRV_FEAT, 32'h2000_0000));
    endtask

    // Pending count versus ack value, mismatch report, status reset.
    task automatic test_interrupt_ack();
        send_access(beat(OP_RAISE, '0, '0));
        send_access(beat(OP_RAISE, '1, '1));
        send_access(beat(OP_WRITE, OFF_IRQ_ACK, 32'd1));
        send_access(beat(OP_WRITE, OFF_IRQ_ACK, 32'd2));
        send_access(beat(OP_WRITE, OFF_IRQ_ACK, 32'd1));
        send_access(beat(OP_WRITE, OFF_IRQ_ACK, 32'd1));
        send_access(beat(OP_READ, OFF_IRQ_STATUS, '0));
        send_access(beat(OP_RAISE, '0, '0));
        send_access(beat(OP_WRITE, OFF_STATUS, 32'd0));
        send_access(beat(OP_READ, OFF_IRQ_STATUS, '0));
    endtask

    // Pending count back to back: a run of raises is retired one per
    // matching ack, then one more ack clears the bit.
    task automatic test_pending_count();
        settle_bus();
        sender_gaps = 1'b0;
        repeat (PENDING_RUN)
            send_access(beat(OP_RAISE, 12'($urandom), $urandom));
        repeat (PENDING_RUN + 1)
            send_access(beat(OP_WRITE, OFF_IRQ_ACK, 32'd1));
        send_access(beat(OP_READ, OFF_IRQ_STATUS, '0));
        send_access(beat(OP_WRITE, OFF_STATUS, 32'd0));
        settle_bus();
        sender_gaps = 1'b1;
    endtask

    // Mixed traffic with bring-up sequences; gaps switch on and off in
    // stretches, and now and then the sender waits for every reply.
    task automatic test_random_traffic(input int count, input bit no_gaps);
        int target;
        target = beats_sent + count;
        sender_gaps = !no_gaps;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                if (!no_gaps)
                    sender_gaps = ($urandom_range(0, 2) != 0);
                if (!no_gaps && $urandom_range(0, 2) == 0)
                    settle_bus();
            end
            if ($urandom_range(0, 19) == 0)
                driver_bringup();
            else
                send_access(random_access());
        end
    endtask

    initial
    begin
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_reads();
        test_refused_accesses();
        test_queues_and_features();
        test_interrupt_ack();
        test_pending_count();

        apply_settings(8'($urandom), {$urandom, $urandom}, 16'd256, 4'd1, $urandom, 2'd2);
        test_random_traffic(300, 1'b0);
        apply_settings(8'd0, 64'd0, 16'd0, 4'd1, 32'd0, 2'd1);
        test_random_traffic(300, 1'b0);
        apply_settings(8'hff, '1, 16'd32768, 4'd8, 32'hffffffff, 2'd2);
        test_random_traffic(300, 1'b0);
        apply_settings(8'($urandom), {$urandom, $urandom}, 16'($urandom_range(0, 32768)),
                       4'($urandom_range(1, 8)), $urandom, 2'($urandom_range(1, 2)));
        test_random_traffic(300, 1'b0);
        apply_settings(8'($urandom), {$urandom, $urandom}, 16'($urandom_range(0, 32768)),
                       4'($urandom_range(1, 8)), $urandom, 2'($urandom_range(1, 2)));
        test_random_traffic(300, 1'b1);

        settle_bus();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("virtio_mmio_transport_registers_tb OK");
        else
            $display("virtio_mmio_transport_registers_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
hdl/vmmio_pkg.sv
hdl/virtio_mmio_transport_registers.sv
tb/virtio_mmio_transport_registers_tb.sv
